// ===== rtl/lcd4_pkg.sv =====
// lcd4_pkg: command codes, wait classes and byte tables for the lcd 4-bit
// command sequencer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lcd4_pkg;

  typedef enum logic [2:0] {
    FUNC_INIT     = 3'd0,
    FUNC_CLEAR    = 3'd1,
    FUNC_HOME     = 3'd2,
    FUNC_CURSOR   = 3'd3,
    FUNC_CHAR     = 3'd4,
    FUNC_CONTRAST = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    WAIT_SHORT  = 2'd0,
    WAIT_NORMAL = 2'd1,
    WAIT_LONG   = 2'd2
  } wait_e;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned ValueW = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned WaitW  = 2;
  localparam int unsigned IdxW   = 5;

  localparam logic [7:0] BYTE_FUNC_EXT   = 8'h29;
  localparam logic [7:0] BYTE_BIAS       = 8'h15;
  localparam logic [7:0] BYTE_POWER      = 8'h55;
  localparam logic [7:0] BYTE_FOLLOWER   = 8'h6E;
  localparam logic [7:0] BYTE_CONTRAST   = 8'h72;
  localparam logic [7:0] BYTE_FUNC_STD   = 8'h28;
  localparam logic [7:0] BYTE_DISP_ON    = 8'h0C;
  localparam logic [7:0] BYTE_CLEAR      = 8'h01;
  localparam logic [7:0] BYTE_ENTRY      = 8'h06;
  localparam logic [7:0] BYTE_HOME       = 8'h02;
  localparam logic [7:0] BYTE_DDRAM      = 8'h80;
  localparam logic [7:0] BYTE_POWER_BASE = 8'h54;
  localparam logic [7:0] BYTE_CONTR_BASE = 8'h70;

  localparam logic [5:0]  CONTRAST_MAX = 6'd63;
  // floor(63*v/100) == (v * 330309) >> 19 for all 8-bit v
  localparam logic [18:0] CONTRAST_MUL = 19'd330309;
  localparam int unsigned CONTRAST_SH  = 19;

  localparam logic [3:0] INIT_CLEAR_IDX = 4'd9;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = BYTE_FUNC_EXT;
      4'd1:    b = BYTE_FUNC_EXT;
      4'd2:    b = BYTE_FUNC_EXT;
      4'd3:    b = BYTE_BIAS;
      4'd4:    b = BYTE_POWER;
      4'd5:    b = BYTE_FOLLOWER;
      4'd6:    b = BYTE_CONTRAST;
      4'd7:    b = BYTE_FUNC_STD;
      4'd8:    b = BYTE_DISP_ON;
      4'd9:    b = BYTE_CLEAR;
      4'd10:   b = BYTE_ENTRY;
      default: b = BYTE_ENTRY;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] num_bytes(input func_e f);
    logic [3:0] n;
    case (f)
      FUNC_INIT:     n = 4'd11;
      FUNC_CONTRAST: n = 4'd4;
      default:       n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] cmd_byte(input func_e f, input logic [7:0] value,
                                          input logic [5:0] scaled,
                                          input logic [3:0] idx);
    logic [7:0] b;
    case (f)
      FUNC_INIT:   b = init_byte(idx);
      FUNC_CLEAR:  b = BYTE_CLEAR;
      FUNC_HOME:   b = BYTE_HOME;
      FUNC_CURSOR: b = BYTE_DDRAM | value;
      FUNC_CHAR:   b = value;
      FUNC_CONTRAST: begin
        case (idx)
          4'd0:    b = BYTE_FUNC_EXT;
          4'd1:    b = BYTE_POWER_BASE | {6'd0, scaled[5:4]};
          4'd2:    b = BYTE_CONTR_BASE | {4'd0, scaled[3:0]};
          default: b = BYTE_FUNC_STD;
        endcase
      end
      default:     b = BYTE_FUNC_STD;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcd4_if.sv =====
// lcd4_cmd_if and lcd4_nib_if: valid/ready channels for commands and nibble words
// depends on lcd4_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lcd4_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [lcd4_pkg::FuncW-1:0]    func;
  logic [lcd4_pkg::ValueW-1:0]   value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface lcd4_nib_if;
  logic                          valid;
  logic                          ready;
  logic                          reg_select;
  logic [lcd4_pkg::NibW-1:0]     nibble;
  logic [lcd4_pkg::WaitW-1:0]    wait_class;
  logic                          last;

  modport source (output valid, output reg_select, output nibble, output wait_class,
                  output last, input ready);
  modport sink   (input valid, input reg_select, input nibble, input wait_class,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcd_4bit_command_sequencer_core.sv =====
// lcd 4-bit command sequencer: command register, nibble index, output register
// the first nibble word passes the command register, then the output register
// one word per cycle unless stalled; words: init 22, contrast 8, other commands 2
// the next command is taken in the cycle its predecessor's last nibble is issued
// func codes 6 and 7 are accepted and produce no words
// reset clears the command and output valid flags; depends on lcd4_pkg, lcd4_if
`timescale 1ns / 1ps
`default_nettype none

module lcd_4bit_command_sequencer_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lcd4_cmd_if.sink   cmd_i,
  lcd4_nib_if.source nib_o
);

  logic                           cmd_vld_q, cmd_vld_d;
  lcd4_pkg::func_e                func_q, func_d;
  logic [lcd4_pkg::ValueW-1:0]    value_q, value_d;
  logic [lcd4_pkg::IdxW-1:0]      idx_q, idx_d;

  logic                           out_vld_q, out_vld_d;
  logic                           rs_q, rs_d;
  logic [lcd4_pkg::NibW-1:0]      nib_q, nib_d;
  lcd4_pkg::wait_e                wait_q, wait_d;
  logic                           last_q, last_d;

  logic                           out_free, step, accept, in_known;
  logic [26:0]                    prod;
  logic [7:0]                     scaled_raw;
  logic [5:0]                     scaled;
  logic [3:0]                     bidx;
  logic                           half;
  logic [7:0]                     cur_byte;
  logic                           cur_last, cur_long;

  // contrast scaling
  assign prod       = {19'd0, value_q} * {8'd0, lcd4_pkg::CONTRAST_MUL};
  assign scaled_raw = prod[26:lcd4_pkg::CONTRAST_SH];
  assign scaled     = (scaled_raw > {2'd0, lcd4_pkg::CONTRAST_MAX}) ?
                      lcd4_pkg::CONTRAST_MAX : scaled_raw[5:0];

  assign bidx     = idx_q[4:1];
  assign half     = idx_q[0];
  assign cur_byte = lcd4_pkg::cmd_byte(func_q, value_q, scaled, bidx);
  assign cur_last = half && (bidx == lcd4_pkg::num_bytes(func_q) - 4'd1);
  assign cur_long = (func_q == lcd4_pkg::FUNC_CLEAR) || (func_q == lcd4_pkg::FUNC_HOME) ||
                    ((func_q == lcd4_pkg::FUNC_INIT) && (bidx == lcd4_pkg::INIT_CLEAR_IDX));

  assign out_free    = !out_vld_q || nib_o.ready;
  assign step        = cmd_vld_q && out_free;
  assign cmd_i.ready = !cmd_vld_q || (step && cur_last);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign in_known    = (cmd_i.func <= 3'(lcd4_pkg::FUNC_CONTRAST));

  always_comb begin
    cmd_vld_d = cmd_vld_q;
    func_d    = func_q;
    value_d   = value_q;
    idx_d     = idx_q;
    if (step) begin
      idx_d = idx_q + 5'd1;
      if (cur_last) begin
        cmd_vld_d = 1'b0;
      end
    end
    if (accept) begin
      cmd_vld_d = in_known;
      func_d    = lcd4_pkg::func_e'(cmd_i.func);
      value_d   = cmd_i.value;
      idx_d     = '0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    rs_d      = rs_q;
    nib_d     = nib_q;
    wait_d    = wait_q;
    last_d    = last_q;
    if (step) begin
      out_vld_d = 1'b1;
      rs_d      = (func_q == lcd4_pkg::FUNC_CHAR);
      nib_d     = half ? cur_byte[3:0] : cur_byte[7:4];
      wait_d    = !half ? lcd4_pkg::WAIT_SHORT :
                  (cur_long ? lcd4_pkg::WAIT_LONG : lcd4_pkg::WAIT_NORMAL);
      last_d    = cur_last;
    end else if (nib_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    value_q <= value_d;
    idx_q   <= idx_d;
    rs_q    <= rs_d;
    nib_q   <= nib_d;
    wait_q  <= wait_d;
    last_q  <= last_d;
  end

  assign nib_o.valid      = out_vld_q;
  assign nib_o.reg_select = rs_q;
  assign nib_o.nibble     = nib_q;
  assign nib_o.wait_class = wait_q;
  assign nib_o.last       = last_q;

endmodule

`default_nettype wire

// ===== rtl/lcd4_chk.sv =====
// lcd4_chk: port-level assertions on the sequencer's nibble word channel
// bound to lcd_4bit_command_sequencer_core; depends on lcd4_pkg for wait class codes
`timescale 1ns / 1ps
`default_nettype none

module lcd4_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       reg_select_i,
  input wire logic [3:0] nibble_i,
  input wire logic [1:0] wait_class_i,
  input wire logic       last_i
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("nibble word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(nibble_i) && $stable(wait_class_i) &&
    $stable(last_i) && $stable(reg_select_i))
    else $error("nibble word changed while stalled");

  // high nibble is never the end of a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (wait_class_i == lcd4_pkg::WAIT_SHORT) |-> !last_i)
    else $error("high nibble flagged last");

  // low nibble of the same byte follows right after a taken high nibble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (wait_class_i == lcd4_pkg::WAIT_SHORT) |=>
    out_valid_i && (wait_class_i != lcd4_pkg::WAIT_SHORT) &&
    (reg_select_i == $past(reg_select_i)))
    else $error("low nibble missing after high nibble");

endmodule

bind lcd_4bit_command_sequencer_core lcd4_chk u_lcd4_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (nib_o.valid),
  .out_ready_i  (nib_o.ready),
  .reg_select_i (nib_o.reg_select),
  .nibble_i     (nib_o.nibble),
  .wait_class_i (nib_o.wait_class),
  .last_i       (nib_o.last)
);

`default_nettype wire
